### design/pps_pkg.sv
package pps_pkg;

  // Sizing
  localparam int LEVEL_COUNT = 5;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 16;

  // Fixed field widths of the ports
  localparam int PID_W    = 16;
  localparam int LVL_W    = 3;
  localparam int STATUS_W = 2;

  // Derived widths
  localparam int KEEP_W    = (PID_BITS < PID_W) ? PID_BITS : PID_W;
  localparam int LVL_IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = LVL_IDX_W + PTR_W;
  localparam int RAM_DEPTH = LEVEL_COUNT << PTR_W;

  // Command codes
  localparam logic CMD_READY   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_IDLE_REL = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_slot;
    logic publish;
  } pps_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_read;
  } pps_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

### design/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pps_ctrl.sv
module pps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pps_pkg::pps_stat_t stat,
  output pps_pkg::pps_cmd_t  cmd
);
  import pps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_read ? S_READ : S_OUT;
      end
      S_READ: begin
        cmd.load_slot = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/pps_dpath.sv
module pps_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pps_pkg::pps_cmd_t                   cmd,
  output pps_pkg::pps_stat_t                  stat,
  input  logic                                in_cmd,
  input  logic [pps_pkg::PID_W-1:0]           in_process_id,
  input  logic [pps_pkg::LVL_W-1:0]           in_priority_level,
  output logic                                out_running_valid,
  output logic [pps_pkg::PID_W-1:0]           out_running_pid,
  output logic [pps_pkg::LVL_W-1:0]           out_running_level,
  output logic                                out_preempt_flag,
  output logic [pps_pkg::PID_W-1:0]           out_preempted_pid,
  output logic [pps_pkg::STATUS_W-1:0]        out_status
);
  import pps_pkg::*;

  // Captured item
  logic                 cmd_r;
  logic [KEEP_W-1:0]    pid_r;
  logic [LVL_IDX_W-1:0] lvl_r;
  logic [LVL_IDX_W-1:0] sat_lvl;

  // Running slot
  logic                 slot_busy_r, slot_busy_nxt;
  logic [KEEP_W-1:0]    slot_pid_r, slot_pid_nxt;
  logic [LVL_IDX_W-1:0] slot_level_r, slot_level_nxt;

  // Queue pointers
  logic [PTR_W-1:0] head_r  [LEVEL_COUNT];
  logic [PTR_W-1:0] head_nxt[LEVEL_COUNT];
  logic [PTR_W-1:0] tail_r  [LEVEL_COUNT];
  logic [PTR_W-1:0] tail_nxt[LEVEL_COUNT];
  logic [CNT_W-1:0] count_r  [LEVEL_COUNT];
  logic [CNT_W-1:0] count_nxt[LEVEL_COUNT];

  // Pending result
  logic                 res_pflag_r;
  logic [KEEP_W-1:0]    res_ppid_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [LVL_IDX_W-1:0] disp_lvl_r;

  // Decode
  logic                 is_ready, is_release;
  logic                 preempt;
  logic [LVL_IDX_W-1:0] push_lvl;
  logic [KEEP_W-1:0]    push_pid;
  logic                 push_full;
  logic                 do_push, do_pop;
  logic                 any_ne;
  logic [LVL_IDX_W-1:0] top_lvl;
  logic [KEEP_W-1:0]    ram_rdata;

  assign sat_lvl = (int'(in_priority_level) >= LEVEL_COUNT) ?
                   LVL_IDX_W'(LEVEL_COUNT - 1) : LVL_IDX_W'(in_priority_level);

  assign is_ready   = (cmd_r == CMD_READY);
  assign is_release = (cmd_r == CMD_RELEASE);
  assign preempt    = slot_busy_r && (slot_level_r < lvl_r);
  assign push_lvl   = preempt ? slot_level_r : lvl_r;
  assign push_pid   = preempt ? slot_pid_r : pid_r;
  assign push_full  = (count_r[push_lvl] == CNT_W'(QUEUE_DEPTH));

  // Highest non-empty level; later (higher) levels override
  always_comb begin
    any_ne  = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (count_r[l] != '0) begin
        any_ne  = 1'b1;
        top_lvl = LVL_IDX_W'(l);
      end
    end
  end

  assign stat.need_read = is_release && slot_busy_r && any_ne;
  assign do_push = cmd.exec && is_ready && slot_busy_r && !push_full;
  assign do_pop  = cmd.exec && stat.need_read;

  always_comb begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      head_nxt[l]  = head_r[l];
      tail_nxt[l]  = tail_r[l];
      count_nxt[l] = count_r[l];
    end
    if (do_push) begin
      tail_nxt[push_lvl]  = ptr_inc(tail_r[push_lvl]);
      count_nxt[push_lvl] = count_r[push_lvl] + 1'b1;
    end
    if (do_pop) begin
      head_nxt[top_lvl]  = ptr_inc(head_r[top_lvl]);
      count_nxt[top_lvl] = count_r[top_lvl] - 1'b1;
    end
  end

  always_comb begin
    slot_busy_nxt  = slot_busy_r;
    slot_pid_nxt   = slot_pid_r;
    slot_level_nxt = slot_level_r;
    if (cmd.exec) begin
      if (is_release) begin
        if (slot_busy_r) begin
          slot_busy_nxt  = 1'b0;
          slot_pid_nxt   = '0;
          slot_level_nxt = '0;
        end
      end else if (!slot_busy_r || preempt) begin
        slot_busy_nxt  = 1'b1;
        slot_pid_nxt   = pid_r;
        slot_level_nxt = lvl_r;
      end
    end else if (cmd.load_slot) begin
      slot_busy_nxt  = 1'b1;
      slot_pid_nxt   = ram_rdata;
      slot_level_nxt = disp_lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_busy_r  <= 1'b0;
      slot_pid_r   <= '0;
      slot_level_r <= '0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        head_r[l]  <= '0;
        tail_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      slot_busy_r  <= slot_busy_nxt;
      slot_pid_r   <= slot_pid_nxt;
      slot_level_r <= slot_level_nxt;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        head_r[l]  <= head_nxt[l];
        tail_r[l]  <= tail_nxt[l];
        count_r[l] <= count_nxt[l];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      pid_r <= in_process_id[KEEP_W-1:0];
      lvl_r <= sat_lvl;
    end
    if (cmd.exec) begin
      disp_lvl_r  <= top_lvl;
      res_pflag_r <= is_ready && preempt;
      res_ppid_r  <= (is_ready && preempt) ? slot_pid_r : '0;
      if (is_release && !slot_busy_r) begin
        res_status_r <= STAT_IDLE_REL;
      end else if (is_ready && slot_busy_r && push_full) begin
        res_status_r <= STAT_FULL;
      end else begin
        res_status_r <= STAT_OK;
      end
    end
    if (cmd.publish) begin
      out_running_valid <= slot_busy_r;
      out_running_pid   <= slot_busy_r ? PID_W'(slot_pid_r) : '0;
      out_running_level <= slot_busy_r ? LVL_W'(slot_level_r) : '0;
      out_preempt_flag  <= res_pflag_r;
      out_preempted_pid <= PID_W'(res_ppid_r);
      out_status        <= res_status_r;
    end
  end

  pps_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr ({push_lvl, tail_r[push_lvl]}),
    .wdata (push_pid),
    .raddr ({top_lvl, head_r[top_lvl]}),
    .rdata (ram_rdata)
  );

endmodule

### design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: one running slot plus a FIFO ready queue
// per priority level (highest level wins).
// Input channel (in_valid/in_ready): in_cmd = 0 makes in_process_id ready at
//   in_priority_level (levels above the top one saturate); in_cmd = 1
//   releases the runner and dispatches the head of the highest non-empty
//   queue. A newcomer with a strictly higher level preempts the runner,
//   which goes back to the tail of its own level's queue.
// Output channel (out_valid/out_ready): one transfer per accepted item,
//   showing the slot after the item, the preempted id if any, and status
//   (ok, queue full with an id dropped, release while idle).
// Sequencing: an item is handled one at a time. A ready item or a release
//   with empty queues goes from accept through execute to publish; a
//   release that dispatches adds a step between them for the registered
//   read of the queue RAM. The next item is accepted as soon as the result
//   moves into the output register.
// Stall: a held result does not block the next accept; the following
//   result waits in the datapath result registers until the output
//   register is taken.
// Reset: slot empty, all queues empty, no result pending. The queue RAM is
//   not cleared; only written entries are ever read.
module preemptive_priority_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [pps_pkg::PID_W-1:0]     in_process_id,
  input  logic [pps_pkg::LVL_W-1:0]     in_priority_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_running_valid,
  output logic [pps_pkg::PID_W-1:0]     out_running_pid,
  output logic [pps_pkg::LVL_W-1:0]     out_running_level,
  output logic                          out_preempt_flag,
  output logic [pps_pkg::PID_W-1:0]     out_preempted_pid,
  output logic [pps_pkg::STATUS_W-1:0]  out_status
);
  import pps_pkg::*;

  pps_cmd_t  cmd;
  pps_stat_t stat;

  // Sequencer: accept, execute, optional RAM read, publish
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slot, queue pointers, queue RAM and result registers
  pps_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_process_id     (in_process_id),
    .in_priority_level (in_priority_level),
    .out_running_valid (out_running_valid),
    .out_running_pid   (out_running_pid),
    .out_running_level (out_running_level),
    .out_preempt_flag  (out_preempt_flag),
    .out_preempted_pid (out_preempted_pid),
    .out_status        (out_status)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the preemptive priority scheduler.
// A queue of requests (directed first, then random episodes) feeds a clocked
// driver that sends in bursts with random gaps. A second clocked block watches
// both channels. For every input transfer it runs a cycle-free scheduler
// model and queues the expected view. Every output transfer is compared with
// the oldest queued view. The receiver stalls on its own pattern and once
// holds off for a long stretch. A watchdog ends the run if the channels go
// quiet for too long.
module tb_top;
  import pps_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int HOLDOFF_AFTER = 300;   // results seen before the long hold-off
  localparam int HOLDOFF_LEN   = 400;
  localparam int IDLE_LIMIT    = 2000;  // well above the hold-off
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    logic              cmd;
    logic [PID_W-1:0]  pid;
    logic [LVL_W-1:0]  lvl;
    bit                wait_idle;  // sender waits for all results first
  } sched_req_t;

  typedef struct {
    logic                run_v;
    logic [PID_W-1:0]    run_pid;
    logic [LVL_W-1:0]    run_lvl;
    logic                pre_f;
    logic [PID_W-1:0]    pre_pid;
    logic [STATUS_W-1:0] stat;
  } sched_view_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_cmd = CMD_READY;
  logic [PID_W-1:0]    in_process_id = '0;
  logic [LVL_W-1:0]    in_priority_level = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_running_valid;
  logic [PID_W-1:0]    out_running_pid;
  logic [LVL_W-1:0]    out_running_level;
  logic                out_preempt_flag;
  logic [PID_W-1:0]    out_preempted_pid;
  logic [STATUS_W-1:0] out_status;

  preemptive_priority_scheduler u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_process_id     (in_process_id),
    .in_priority_level (in_priority_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_running_valid (out_running_valid),
    .out_running_pid   (out_running_pid),
    .out_running_level (out_running_level),
    .out_preempt_flag  (out_preempt_flag),
    .out_preempted_pid (out_preempted_pid),
    .out_status        (out_status)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scheduler model: one CPU slot plus a FIFO of ids per level
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0] runq_ids [LEVEL_COUNT][QUEUE_DEPTH];
  int               runq_head [LEVEL_COUNT];
  int               runq_tail [LEVEL_COUNT];
  int               runq_fill [LEVEL_COUNT];
  bit               cpu_busy;
  logic [PID_W-1:0] cpu_pid;
  int               cpu_lvl;

  // Tail insert; returns 0 when the level's FIFO is already full.
  function automatic bit runq_append(int lv, logic [PID_W-1:0] id);
    if (runq_fill[lv] >= QUEUE_DEPTH) return 1'b0;
    runq_ids[lv][runq_tail[lv]] = id;
    runq_tail[lv] = (runq_tail[lv] == QUEUE_DEPTH - 1) ? 0 : runq_tail[lv] + 1;
    runq_fill[lv]++;
    return 1'b1;
  endfunction

  // Applies one request to the model and returns the view it leaves behind.
  function automatic sched_view_t sched_apply(logic cmd, logic [PID_W-1:0] pid,
                                              logic [LVL_W-1:0] lvl);
    sched_view_t      v;
    int               lv;
    logic [PID_W-1:0] id;
    v = '{default: '0};
    if (cmd == CMD_RELEASE) begin
      if (!cpu_busy) begin
        v.stat = STAT_IDLE_REL;
      end else begin
        cpu_busy = 1'b0;
        cpu_pid  = '0;
        cpu_lvl  = 0;
        // dispatch from the highest non-empty level
        for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
          if (!cpu_busy && runq_fill[l] != 0) begin
            cpu_pid  = runq_ids[l][runq_head[l]];
            cpu_lvl  = l;
            cpu_busy = 1'b1;
            runq_head[l] = (runq_head[l] == QUEUE_DEPTH - 1) ? 0 : runq_head[l] + 1;
            runq_fill[l]--;
          end
        end
      end
    end else begin
      id = PID_W'(pid[KEEP_W-1:0]);
      lv = (lvl >= LEVEL_COUNT) ? LEVEL_COUNT - 1 : int'(lvl);
      if (!cpu_busy) begin
        cpu_busy = 1'b1;
        cpu_pid  = id;
        cpu_lvl  = lv;
      end else if (cpu_lvl < lv) begin
        // newcomer wins; old runner goes back to its own level
        v.pre_f   = 1'b1;
        v.pre_pid = cpu_pid;
        if (!runq_append(cpu_lvl, cpu_pid)) v.stat = STAT_FULL;
        cpu_pid = id;
        cpu_lvl = lv;
      end else if (!runq_append(lv, id)) begin
        v.stat = STAT_FULL;
      end
    end
    v.run_v   = cpu_busy;
    v.run_pid = cpu_busy ? cpu_pid : '0;
    v.run_lvl = cpu_busy ? LVL_W'(cpu_lvl) : '0;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  sched_req_t  pending_reqs[$];
  sched_view_t expected_views[$];
  int          mismatches;
  int          in_flight;     // transfers in minus transfers out, NBA-updated
  int          results_seen;  // NBA-updated

  task automatic add_req(logic cmd, logic [PID_W-1:0] pid, logic [LVL_W-1:0] lvl,
                         bit wait_idle);
    sched_req_t r;
    r.cmd       = cmd;
    r.pid       = pid;
    r.lvl       = lvl;
    r.wait_idle = wait_idle;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic log_mismatch(string what, longint got, longint want);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  initial begin
    int n;
    int kind;
    int len;
    int focus;
    bit hold;
    bit first;

    // Directed: release on an empty slot, id zero, all-ones id, level
    // saturation (5, 6, 7), equal-level queueing, preemption, dispatch order
    // across levels, release with all queues empty, then release when idle.
    add_req(CMD_RELEASE, 16'h1357, 3'd0, 1'b0);
    add_req(CMD_READY,   16'h0000, 3'd0, 1'b0);
    add_req(CMD_READY,   16'hFFFF, 3'd7, 1'b0);
    add_req(CMD_READY,   16'h1234, 3'd4, 1'b0);
    add_req(CMD_READY,   16'hABCD, 3'd5, 1'b0);
    add_req(CMD_READY,   16'h5555, 3'd6, 1'b0);
    add_req(CMD_READY,   16'hAAAA, 3'd2, 1'b0);
    add_req(CMD_READY,   16'h8001, 3'd1, 1'b0);
    add_req(CMD_READY,   16'h7FFE, 3'd3, 1'b0);
    for (int i = 0; i < 9; i++) add_req(CMD_RELEASE, PID_W'($urandom()), 3'd7, 1'b0);
    // lower newcomer onto a busy slot, then a strict preemption at level 3
    add_req(CMD_READY,   16'h0F0F, 3'd2, 1'b0);
    add_req(CMD_READY,   16'h00FF, 3'd1, 1'b0);
    add_req(CMD_READY,   16'hF0F0, 3'd3, 1'b0);

    // Random episodes. Fill and stack episodes push queues to full; drain
    // episodes empty the system and hit releases on an idle slot.
    n     = 0;
    first = 1'b1;
    while (n < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 9);
      hold  = first || ($urandom_range(0, 9) == 0);
      first = 1'b0;
      focus = $urandom_range(0, LEVEL_COUNT - 1);
      case (kind)
        0, 1, 2, 3: begin  // mixed traffic
          len = $urandom_range(20, 60);
          for (int i = 0; i < len; i++) begin
            add_req(($urandom_range(0, 99) < 45) ? CMD_RELEASE : CMD_READY,
                    PID_W'($urandom()), LVL_W'($urandom_range(0, 7)), hold && i == 0);
          end
          n += len;
        end
        4, 5: begin  // fill, mostly one level
          len = $urandom_range(20, 60);
          for (int i = 0; i < len; i++) begin
            add_req(($urandom_range(0, 99) < 85) ? CMD_READY : CMD_RELEASE,
                    PID_W'($urandom()),
                    ($urandom_range(0, 9) < 7) ? LVL_W'(focus) : LVL_W'($urandom_range(0, 7)),
                    hold && i == 0);
          end
          n += len;
        end
        6, 7: begin  // drain
          len = $urandom_range(10, 40);
          for (int i = 0; i < len; i++) begin
            add_req(($urandom_range(0, 99) < 80) ? CMD_RELEASE : CMD_READY,
                    PID_W'($urandom()), LVL_W'($urandom_range(0, 7)), hold && i == 0);
          end
          n += len;
        end
        default: begin
          // Empty out, stack one level past full, then preempt its runner
          // so the preempted id finds its own queue full.
          focus = $urandom_range(0, LEVEL_COUNT - 2);
          len = $urandom_range(10, 40);
          for (int i = 0; i < len; i++)
            add_req(CMD_RELEASE, PID_W'($urandom()), LVL_W'($urandom_range(0, 7)), hold && i == 0);
          n += len;
          len = QUEUE_DEPTH + $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            add_req(CMD_READY, PID_W'($urandom()), LVL_W'(focus), 1'b0);
          n += len;
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++)
            add_req(CMD_READY, PID_W'($urandom()), LVL_W'($urandom_range(focus + 1, 7)), 1'b0);
          n += len;
        end
      endcase
    end

    // Reset once at the start of the run.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be sent and every result checked.
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || in_flight != 0);
    // Let anything stray come out before the final verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_views.size() != 0)
      log_mismatch("results never delivered", 0, expected_views.size());
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    sched_req_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      // free to present a new item (nothing offered, or a transfer just now)
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].wait_idle && (in_valid || in_flight != 0))) begin
        // a drain pause holds until every expected result has come back
        in_valid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        in_valid          <= 1'b1;
        in_cmd            <= nxt.cmd;
        in_process_id     <= nxt.pid;
        in_priority_level <= nxt.lvl;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall modes of random length, plus one long hold-off
  // ---------------------------------------------------------------------------
  int rx_mode;
  int rx_mode_left;
  int holdoff_left;
  bit holdoff_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rx_mode      <= 0;
      rx_mode_left <= 0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
      // sender keeps offering; the block backs up and drops in_ready
      holdoff_left <= HOLDOFF_LEN;
      holdoff_done <= 1'b1;
      out_ready    <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, check on output transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sched_view_t want;
    int          d_in;
    int          d_out;
    if (!rst_n) begin
      in_flight    <= 0;
      results_seen <= 0;
    end else begin
      d_in  = (in_valid && in_ready) ? 1 : 0;
      d_out = 0;
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          log_mismatch("result with nothing expected, running_pid", out_running_pid, 0);
        end else begin
          want  = expected_views.pop_front();
          d_out = 1;
          if (out_running_valid !== want.run_v)
            log_mismatch("running_valid", out_running_valid, want.run_v);
          if (out_running_pid !== want.run_pid)
            log_mismatch("running_pid", out_running_pid, want.run_pid);
          if (out_running_level !== want.run_lvl)
            log_mismatch("running_level", out_running_level, want.run_lvl);
          if (out_preempt_flag !== want.pre_f)
            log_mismatch("preempt_flag", out_preempt_flag, want.pre_f);
          if (out_preempted_pid !== want.pre_pid)
            log_mismatch("preempted_pid", out_preempted_pid, want.pre_pid);
          if (out_status !== want.stat)
            log_mismatch("status", out_status, want.stat);
        end
      end
      if (d_in != 0)
        expected_views.insert(expected_views.size(),
                              sched_apply(in_cmd, in_process_id, in_priority_level));
      in_flight    <= in_flight + d_in - d_out;
      results_seen <= results_seen + d_out;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles without any transfer ends the run
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
